@@ hdl/lcdws_pkg.sv @@
`timescale 1ns / 1ps

package lcdws_pkg;

  typedef enum logic [1:0] {
    OP_SET_PIXEL   = 2'd0,
    OP_READ_PIXEL  = 2'd1,
    OP_OPEN_WINDOW = 2'd2,
    OP_WRITE_WORD  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ACC_CMD  = 2'd0,
    ACC_DATA = 2'd1,
    ACC_READ = 2'd2,
    ACC_NONE = 2'd3
  } access_kind_t;

  typedef enum logic [2:0] {
    REQ_SET,
    REQ_READ,
    REQ_WINDOW,
    REQ_WORD,
    REQ_FAIL
  } req_kind_t;

  localparam logic [2:0] STAT_OK      = 3'd0;
  localparam logic [2:0] STAT_X0_BAD  = 3'd1;
  localparam logic [2:0] STAT_X1_BAD  = 3'd2;
  localparam logic [2:0] STAT_Y0_BAD  = 3'd3;
  localparam logic [2:0] STAT_Y1_BAD  = 3'd4;

  localparam logic [15:0] CMD_COLUMN = 16'h002a;
  localparam logic [15:0] CMD_PAGE   = 16'h002b;
  localparam logic [15:0] CMD_WRITE  = 16'h002c;
  localparam logic [15:0] CMD_READ   = 16'h002e;
  localparam logic [7:0]  BYTE_MASK  = 8'hff;

  // Positions of the accesses within one addressed request.
  localparam logic [3:0] STEP_COL_CMD  = 4'd0;
  localparam logic [3:0] STEP_X_LO_HI  = 4'd1;
  localparam logic [3:0] STEP_X_LO_LO  = 4'd2;
  localparam logic [3:0] STEP_X_HI_HI  = 4'd3;
  localparam logic [3:0] STEP_X_HI_LO  = 4'd4;
  localparam logic [3:0] STEP_PAGE_CMD = 4'd5;
  localparam logic [3:0] STEP_Y_LO_HI  = 4'd6;
  localparam logic [3:0] STEP_Y_LO_LO  = 4'd7;
  localparam logic [3:0] STEP_Y_HI_HI  = 4'd8;
  localparam logic [3:0] STEP_Y_HI_LO  = 4'd9;
  localparam logic [3:0] STEP_MEM_CMD  = 4'd10;
  localparam logic [3:0] STEP_PIXEL    = 4'd11;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    req_kind_t   kind;
    logic [2:0]  status;
    logic [15:0] x_lo;
    logic [15:0] x_hi;
    logic [15:0] y_lo;
    logic [15:0] y_hi;
    logic [15:0] color;
  } req_t;

endpackage

@@ hdl/lcdws_front.sv @@
`timescale 1ns / 1ps

module lcdws_front #(
  parameter int MAX_X = 479,
  parameter int MAX_Y = 319
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          opcode,
  input  logic [15:0]         x_start,
  input  logic [15:0]         x_end,
  input  logic [15:0]         y_start,
  input  logic [15:0]         y_end,
  input  logic [15:0]         pixel_color,
  input  logic                queue_full,
  output logic                busy,
  output logic                push,
  output lcdws_pkg::req_t     push_req
);

  localparam logic [15:0] MaxX = 16'(MAX_X);
  localparam logic [15:0] MaxY = 16'(MAX_Y);

  logic            stage_valid;
  lcdws_pkg::req_t stage_req;
  lcdws_pkg::req_t classified;
  logic            accept;
  logic            x0_bad, x1_bad, y0_bad, y1_bad;

  assign x0_bad = x_start > MaxX;
  assign x1_bad = x_end > MaxX;
  assign y0_bad = y_start > MaxY;
  assign y1_bad = y_end > MaxY;

  always_comb begin
    classified.status = lcdws_pkg::STAT_OK;
    classified.color  = pixel_color;
    classified.x_lo   = x_start;
    classified.x_hi   = x_start;
    classified.y_lo   = y_start;
    classified.y_hi   = y_start;
    case (lcdws_pkg::opcode_t'(opcode))
      lcdws_pkg::OP_WRITE_WORD: begin
        classified.kind = lcdws_pkg::REQ_WORD;
      end
      lcdws_pkg::OP_OPEN_WINDOW: begin
        classified.kind = lcdws_pkg::REQ_WINDOW;
        // Corners go out in ascending order on each axis.
        if (x_start > x_end) begin
          classified.x_lo = x_end;
        end else begin
          classified.x_hi = x_end;
        end
        if (y_start > y_end) begin
          classified.y_lo = y_end;
        end else begin
          classified.y_hi = y_end;
        end
        if (x0_bad) begin
          classified.kind   = lcdws_pkg::REQ_FAIL;
          classified.status = lcdws_pkg::STAT_X0_BAD;
        end else if (x1_bad) begin
          classified.kind   = lcdws_pkg::REQ_FAIL;
          classified.status = lcdws_pkg::STAT_X1_BAD;
        end else if (y0_bad) begin
          classified.kind   = lcdws_pkg::REQ_FAIL;
          classified.status = lcdws_pkg::STAT_Y0_BAD;
        end else if (y1_bad) begin
          classified.kind   = lcdws_pkg::REQ_FAIL;
          classified.status = lcdws_pkg::STAT_Y1_BAD;
        end
      end
      default: begin
        if (lcdws_pkg::opcode_t'(opcode) == lcdws_pkg::OP_SET_PIXEL) begin
          classified.kind = lcdws_pkg::REQ_SET;
        end else begin
          classified.kind = lcdws_pkg::REQ_READ;
        end
        if (x0_bad) begin
          classified.kind   = lcdws_pkg::REQ_FAIL;
          classified.status = lcdws_pkg::STAT_X0_BAD;
        end else if (y0_bad) begin
          classified.kind   = lcdws_pkg::REQ_FAIL;
          classified.status = lcdws_pkg::STAT_Y0_BAD;
        end
      end
    endcase
  end

  assign push     = stage_valid && !queue_full;
  assign busy     = stage_valid && queue_full;
  assign accept   = start && !busy;
  assign push_req = stage_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (push) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_req <= classified;
    end
  end

endmodule

@@ hdl/lcdws_queue.sv @@
`timescale 1ns / 1ps

module lcdws_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lcdws_pkg::req_t push_req,
  input  logic            pop,
  output logic            full,
  output logic            head_valid,
  output lcdws_pkg::req_t head_req
);

  localparam int PtrW = $clog2(lcdws_pkg::QUEUE_DEPTH);
  localparam int CntW = $clog2(lcdws_pkg::QUEUE_DEPTH + 1);

  lcdws_pkg::req_t entries [lcdws_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full       = count == CntW'(lcdws_pkg::QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_req   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_req;
    end
  end

endmodule

@@ hdl/lcdws_back.sv @@
`timescale 1ns / 1ps

module lcdws_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  lcdws_pkg::req_t head_req,
  output logic            pop,
  output logic            strobe,
  output logic [1:0]      access_kind,
  output logic [15:0]     bus_value,
  output logic [2:0]      status,
  output logic            last_of_run
);

  logic [3:0]                step;
  logic [3:0]                step_next;
  logic [3:0]                last_step;
  lcdws_pkg::access_kind_t   kind_now;
  logic [15:0]               value_now;
  logic                      is_last;

  always_comb begin
    case (head_req.kind)
      lcdws_pkg::REQ_WINDOW: last_step = lcdws_pkg::STEP_MEM_CMD;
      lcdws_pkg::REQ_SET,
      lcdws_pkg::REQ_READ:   last_step = lcdws_pkg::STEP_PIXEL;
      default:               last_step = lcdws_pkg::STEP_COL_CMD;
    endcase
  end

  assign is_last   = step == last_step;
  assign pop       = head_valid && is_last;
  assign step_next = is_last ? lcdws_pkg::STEP_COL_CMD : step + 4'd1;

  always_comb begin
    kind_now  = lcdws_pkg::ACC_DATA;
    value_now = '0;
    case (head_req.kind)
      lcdws_pkg::REQ_FAIL: begin
        kind_now = lcdws_pkg::ACC_NONE;
      end
      lcdws_pkg::REQ_WORD: begin
        value_now = head_req.color;
      end
      default: begin
        case (step)
          lcdws_pkg::STEP_COL_CMD: begin
            kind_now  = lcdws_pkg::ACC_CMD;
            value_now = lcdws_pkg::CMD_COLUMN;
          end
          lcdws_pkg::STEP_X_LO_HI: value_now = {8'd0, head_req.x_lo[15:8]};
          lcdws_pkg::STEP_X_LO_LO: value_now = {8'd0, head_req.x_lo[7:0] & lcdws_pkg::BYTE_MASK};
          lcdws_pkg::STEP_X_HI_HI: value_now = {8'd0, head_req.x_hi[15:8]};
          lcdws_pkg::STEP_X_HI_LO: value_now = {8'd0, head_req.x_hi[7:0] & lcdws_pkg::BYTE_MASK};
          lcdws_pkg::STEP_PAGE_CMD: begin
            kind_now  = lcdws_pkg::ACC_CMD;
            value_now = lcdws_pkg::CMD_PAGE;
          end
          lcdws_pkg::STEP_Y_LO_HI: value_now = {8'd0, head_req.y_lo[15:8]};
          lcdws_pkg::STEP_Y_LO_LO: value_now = {8'd0, head_req.y_lo[7:0] & lcdws_pkg::BYTE_MASK};
          lcdws_pkg::STEP_Y_HI_HI: value_now = {8'd0, head_req.y_hi[15:8]};
          lcdws_pkg::STEP_Y_HI_LO: value_now = {8'd0, head_req.y_hi[7:0] & lcdws_pkg::BYTE_MASK};
          lcdws_pkg::STEP_MEM_CMD: begin
            kind_now = lcdws_pkg::ACC_CMD;
            if (head_req.kind == lcdws_pkg::REQ_READ) begin
              value_now = lcdws_pkg::CMD_READ;
            end else begin
              value_now = lcdws_pkg::CMD_WRITE;
            end
          end
          lcdws_pkg::STEP_PIXEL: begin
            if (head_req.kind == lcdws_pkg::REQ_READ) begin
              kind_now = lcdws_pkg::ACC_READ;
            end else begin
              value_now = head_req.color;
            end
          end
          default: begin
            kind_now = lcdws_pkg::ACC_NONE;
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step   <= lcdws_pkg::STEP_COL_CMD;
      strobe <= 1'b0;
    end else begin
      strobe <= head_valid;
      if (head_valid) begin
        step <= step_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (head_valid) begin
      access_kind <= kind_now;
      bus_value   <= value_now;
      status      <= head_req.status;
      last_of_run <= is_last;
    end
  end

endmodule

@@ hdl/lcd_window_command_sequencer.sv @@
`timescale 1ns / 1ps
// From start, the first strobed access of a request passes the front register, the queue entry
// and the back end's output registers when the queue is empty. The back end emits one access
// per cycle while the queue holds a request: one for a pixel word or range failure, 11 for an
// open window, 12 for set or read pixel; a four-entry queue lets the front take one per cycle.
// busy rises only while the front register holds a request that the full queue cannot take.
// Synchronous reset empties the front register and the queue and drops the strobe.
module lcd_window_command_sequencer #(
  parameter int MAX_X = 479,
  parameter int MAX_Y = 319
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [15:0] x_start,
  input  logic [15:0] x_end,
  input  logic [15:0] y_start,
  input  logic [15:0] y_end,
  input  logic [15:0] pixel_color,
  output logic        strobe,
  output logic [1:0]  access_kind,
  output logic [15:0] bus_value,
  output logic [2:0]  status,
  output logic        last_of_run
);

  logic            push;
  lcdws_pkg::req_t push_req;
  logic            queue_full;
  logic            head_valid;
  lcdws_pkg::req_t head_req;
  logic            pop;

  lcdws_front #(
    .MAX_X(MAX_X),
    .MAX_Y(MAX_Y)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .opcode     (opcode),
    .x_start    (x_start),
    .x_end      (x_end),
    .y_start    (y_start),
    .y_end      (y_end),
    .pixel_color(pixel_color),
    .queue_full (queue_full),
    .busy       (busy),
    .push       (push),
    .push_req   (push_req)
  );

  lcdws_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_req  (push_req),
    .pop       (pop),
    .full      (queue_full),
    .head_valid(head_valid),
    .head_req  (head_req)
  );

  lcdws_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_req   (head_req),
    .pop        (pop),
    .strobe     (strobe),
    .access_kind(access_kind),
    .bus_value  (bus_value),
    .status     (status),
    .last_of_run(last_of_run)
  );

endmodule
